/* design/ptr_pkg.sv */
// ----------------------------------------------------------------------------
// ptr_pkg: shared types and constants
// Transmit phases, command codes, register indexes, message text lookup and BCD increment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ptr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_BANNER  = 3'd1,
    PH_RECMSG  = 3'd2,
    PH_HEADER  = 3'd3,
    PH_DIGITS  = 3'd4,
    PH_CRLF    = 3'd5,
    PH_SAMPLES = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  localparam logic [1:0] CMD_POLL = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_TXRDY = 2'd2;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_SAMPLE = 1'b1;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50000;
  localparam logic [15:0] SAMPLE_LIMIT_RESET = 16'd30000;

  localparam logic [5:0] BANNER_LEN = 6'd37;
  localparam logic [5:0] RECMSG_LEN = 6'd14;
  localparam logic [5:0] HEADER_LEN = 6'd6;
  localparam logic [5:0] CRLF_LEN = 6'd2;
  localparam logic [5:0] DONE_LEN = 6'd6;

  localparam string BANNER_TXT = "Ready. Press blue button to record.\r\n";
  localparam string RECMSG_TXT = "Recording...\r\n";
  localparam string HEADER_TXT = "AUDIO:";
  localparam string DONE_TXT = "DONE\r\n";

  // Character of a fixed message at a position.
  function automatic logic [7:0] msg_char(input phase_e ph, input logic [5:0] idx);
    logic [7:0] c;
    c = 8'h00;
    unique case (ph)
      PH_BANNER: c = BANNER_TXT[idx];
      PH_RECMSG: c = RECMSG_TXT[idx];
      PH_HEADER: c = HEADER_TXT[idx];
      PH_CRLF:   c = (idx == 6'd0) ? 8'h0D : 8'h0A;
      PH_DONE:   c = DONE_TXT[idx];
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  // Add one to five BCD digits; a digit at nine wraps and carries on.
  function automatic logic [19:0] bcd_inc(input logic [19:0] v);
    logic [19:0] r;
    logic        c;
    r = v;
    c = 1'b1;
    for (int k = 0; k < 5; k++) begin
      if (c) begin
        if (r[4*k +: 4] == 4'd9) begin
          r[4*k +: 4] = 4'd0;
        end else begin
          r[4*k +: 4] = r[4*k +: 4] + 4'd1;
          c = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/ptr_ram.sv */
// ----------------------------------------------------------------------------
// ptr_ram: generic single-port-write, registered-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptr_ram #(
  parameter int Width = 12,
  parameter int Depth = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* design/push_to_record_sample_dumper.sv */
// ----------------------------------------------------------------------------
// push_to_record_sample_dumper: push-to-record audio capture controller
// Debounces a button, records samples into a RAM and dumps them as bytes.
// ----------------------------------------------------------------------------
// One request is taken per cycle for polls, ticks and byte requests alike;
// the request port stalls only while a byte waits in the output register
// and the receiver is not ready. Samples go into a single RAM with one write
// and one registered read port. During a dump the RAM is read one request
// ahead: the address of the sample that the next byte request needs is kept
// presented, so its word is ready when that request arrives; a byte request
// yields its byte into a one-entry output register that is refilled in the
// same cycle it is drained. The sample count is also kept in BCD, advanced
// with every stored sample, so a release hands its digits to the dump at
// once. The banner is queued at reset. Configuration writes set the debounce
// limit (address 0) and the sample limit (address 4).
`timescale 1ns / 1ps
`default_nettype none
module push_to_record_sample_dumper #(
  parameter int SAMPLE_DEPTH = 32768
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic        button_pressed_i,
  input  wire logic [11:0] adc_sample_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic [7:0]       tx_byte_o,
  output logic             end_of_dump_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int AW = $clog2(SAMPLE_DEPTH);

  logic [15:0] deb_lim_q, smp_lim_q;
  logic [16:0] count_q, count_d;      // stored sample count
  logic [19:0] cbcd_q, cbcd_d;        // stored sample count in BCD
  logic        rec_q, rec_d, stable_q, stable_d;
  logic [15:0] deb_q, deb_d;
  ptr_pkg::phase_e ph_q, ph_d;
  logic [5:0]  mi_q, mi_d;
  logic [16:0] di_q, di_d;            // dump index
  logic [19:0] bcd_q, bcd_d;
  logic        half_q, half_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        oe_q, oe_d;

  logic        acc, wr_en, emit;
  logic [11:0] rdata;
  logic [16:0] lim;
  logic [AW-1:0] raddr;
  logic [2:0]  nd;
  logic [7:0]  b;
  logic        eod;

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == ptr_pkg::REG_SAMPLE) prdata[15:0] = smp_lim_q;
    else prdata[15:0] = deb_lim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_lim_q <= ptr_pkg::DEBOUNCE_RESET;
      smp_lim_q <= ptr_pkg::SAMPLE_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == ptr_pkg::REG_DEBOUNCE) deb_lim_q <= pwdata[15:0];
      else smp_lim_q <= pwdata[15:0];
    end
  end

  // Output register drains and refills in the same cycle.
  assign ready_o = !ov_q || ready_i;
  assign acc = valid_i && ready_o;

  // Clamp the sample limit to the store depth.
  assign lim = ({1'b0, smp_lim_q} > 17'(SAMPLE_DEPTH)) ? 17'(SAMPLE_DEPTH)
                                                       : {1'b0, smp_lim_q};
  assign wr_en = acc && command_i == ptr_pkg::CMD_TICK && rec_q && count_q < lim;

  // Present the sample of the current dump index; advance one ahead on emit.
  assign raddr = di_d[AW-1:0];

  ptr_ram #(.Width(12), .Depth(SAMPLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(adc_sample_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    nd = 3'd1;
    if (bcd_d[7:4] != 4'd0) nd = 3'd2;
    if (bcd_d[11:8] != 4'd0) nd = 3'd3;
    if (bcd_d[15:12] != 4'd0) nd = 3'd4;
    if (bcd_d[19:16] != 4'd0) nd = 3'd5;
  end

  // Next state for every request kind.
  always_comb begin
    count_d = count_q; rec_d = rec_q; stable_d = stable_q; deb_d = deb_q;
    ph_d = ph_q; mi_d = mi_q; di_d = di_q; bcd_d = bcd_q; half_d = half_q;
    cbcd_d = cbcd_q;
    b = 8'h00; eod = 1'b0; emit = 1'b0;
    if (wr_en) begin
      count_d = count_q + 17'd1;
      cbcd_d = ptr_pkg::bcd_inc(cbcd_q);
    end
    if (acc && command_i == ptr_pkg::CMD_POLL && ph_q == ptr_pkg::PH_IDLE) begin
      if (button_pressed_i == stable_q) begin
        deb_d = '0;
      end else begin
        deb_d = deb_q + 16'd1;
        if (deb_d >= deb_lim_q) begin
          stable_d = button_pressed_i;
          deb_d = '0;
          mi_d = '0;
          if (button_pressed_i) begin
            count_d = '0;
            cbcd_d = '0;
            rec_d = 1'b1;
            ph_d = ptr_pkg::PH_RECMSG;
          end else begin
            rec_d = 1'b0;
            bcd_d = cbcd_q;
            ph_d = ptr_pkg::PH_HEADER;
            di_d = '0;
            half_d = 1'b0;
          end
        end
      end
    end
    if (acc && command_i == ptr_pkg::CMD_TXRDY && ph_q != ptr_pkg::PH_IDLE) begin
      emit = 1'b1;
      unique case (ph_q)
        ptr_pkg::PH_BANNER, ptr_pkg::PH_RECMSG: begin
          b = ptr_pkg::msg_char(ph_q, mi_q);
          mi_d = mi_q + 6'd1;
          if (mi_d >= ((ph_q == ptr_pkg::PH_BANNER) ? ptr_pkg::BANNER_LEN
                                                    : ptr_pkg::RECMSG_LEN)) begin
            mi_d = '0;
            ph_d = ptr_pkg::PH_IDLE;
          end
        end
        ptr_pkg::PH_HEADER: begin
          b = ptr_pkg::msg_char(ph_q, mi_q);
          mi_d = mi_q + 6'd1;
          if (mi_d >= ptr_pkg::HEADER_LEN) begin
            mi_d = {3'd0, nd};
            ph_d = ptr_pkg::PH_DIGITS;
          end
        end
        ptr_pkg::PH_DIGITS: begin
          b = 8'h30 + {4'd0, bcd_q[4*(mi_q[2:0]-3'd1) +: 4]};
          mi_d = mi_q - 6'd1;
          if (mi_d == 6'd0) ph_d = ptr_pkg::PH_CRLF;
        end
        ptr_pkg::PH_CRLF: begin
          b = ptr_pkg::msg_char(ph_q, mi_q);
          mi_d = mi_q + 6'd1;
          if (mi_d >= ptr_pkg::CRLF_LEN) begin
            mi_d = '0;
            ph_d = (count_q == 17'd0) ? ptr_pkg::PH_DONE : ptr_pkg::PH_SAMPLES;
          end
        end
        ptr_pkg::PH_SAMPLES: begin
          if (!half_q) begin
            b = rdata[7:0];
            half_d = 1'b1;
          end else begin
            b = {4'd0, rdata[11:8]};
            half_d = 1'b0;
            di_d = di_q + 17'd1;
            if (di_d >= count_q) begin
              ph_d = ptr_pkg::PH_DONE;
              mi_d = '0;
            end
          end
        end
        ptr_pkg::PH_DONE: begin
          b = ptr_pkg::msg_char(ph_q, mi_q);
          mi_d = mi_q + 6'd1;
          if (mi_d >= ptr_pkg::DONE_LEN) begin
            mi_d = '0;
            ph_d = ptr_pkg::PH_IDLE;
            eod = 1'b1;
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  // Output register: hold until taken, load on emit.
  always_comb begin
    ov_d = ov_q; ob_d = ob_q; oe_d = oe_q;
    if (ov_q && ready_i) ov_d = 1'b0;
    if (emit) begin
      ov_d = 1'b1; ob_d = b; oe_d = eod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; rec_q <= 1'b0; stable_q <= 1'b0; deb_q <= '0;
      ph_q <= ptr_pkg::PH_BANNER; mi_q <= '0; di_q <= '0; bcd_q <= '0;
      half_q <= 1'b0; ov_q <= 1'b0; cbcd_q <= '0;
    end else begin
      count_q <= count_d; rec_q <= rec_d; stable_q <= stable_d; deb_q <= deb_d;
      ph_q <= ph_d; mi_q <= mi_d; di_q <= di_d; bcd_q <= bcd_d;
      half_q <= half_d; ov_q <= ov_d; cbcd_q <= cbcd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    oe_q <= oe_d;
  end

  assign valid_o = ov_q;
  assign tx_byte_o = ob_q;
  assign end_of_dump_o = oe_q;
endmodule
`default_nettype wire
